FILE: rtl/core/line_cut_point_generator_assert.svh
// Assertion macros for the line cut point generator.
`ifndef LINE_CUT_POINT_GENERATOR_ASSERT_SVH
`define LINE_CUT_POINT_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS
// Checks that a condition holds in the same cycle.
`define LCPG_ASSERT(lbl, ck, rn, pr) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (pr)) \
		else $error("lcpg assertion failed");
// Checks that a trigger implies a condition in the next cycle.
`define LCPG_ASSERT_NEXT(lbl, ck, rn, trig, pr) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (trig) |=> (pr)) \
		else $error("lcpg assertion failed");
`else
`define LCPG_ASSERT(lbl, ck, rn, pr)
`define LCPG_ASSERT_NEXT(lbl, ck, rn, trig, pr)
`endif

`endif

FILE: rtl/core/lcpg_pkg.sv
// Shared constants, types and LFSR helpers of the line cut point generator.
`default_nettype none
package lcpg_pkg;

	localparam int unsigned SHIFTS_PER_LINE = 16;

	localparam int unsigned CW_W    = 60;
	localparam int unsigned CNT_W   = 8;
	localparam int unsigned A_W     = 31;
	localparam int unsigned B_W     = 29;
	localparam int unsigned WORD_W  = 16;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned POS_W   = 10;
	localparam int unsigned ADDR_W  = 5;

	localparam logic [A_W-1:0]    TAPS_A    = 31'h7BB88888;
	localparam logic [B_W-1:0]    TAPS_B    = 29'h17A2C100;
	localparam logic [POS_W-1:0]  CUT_BASE  = 10'd105;
	localparam logic [POS_W-1:0]  LINE_SPAN = 10'd710;
	localparam logic [ADDR_W-1:0] ADDR_TOP  = 5'd30;
	localparam logic [ADDR_W-1:0] ADDR_SAT  = 5'd31;

	// Transaction kinds
	typedef enum logic {
		REQ_RESEED = 1'b0,
		REQ_LINE   = 1'b1
	} req_kind_t;

	// Generator state
	typedef struct packed {
		logic [A_W-1:0]    a;
		logic [B_W-1:0]    b;
		logic [WORD_W-1:0] word;
	} lcpg_state_t;

	// One Galois clock of the 31-bit register
	function automatic logic [A_W-1:0] step_a(input logic [A_W-1:0] v);
		return {1'b0, v[A_W-1:1]} ^ (v[0] ? TAPS_A : '0);
	endfunction

	// One Galois clock of the 29-bit register
	function automatic logic [B_W-1:0] step_b(input logic [B_W-1:0] v);
		return {1'b0, v[B_W-1:1]} ^ (v[0] ? TAPS_B : '0);
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/lcpg_if.sv
// Request and cut result channel interfaces.
`default_nettype none
interface lcpg_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [59:0] codeword;
	logic [7:0]  frame_count;

	modport source (output valid, output req_type, output codeword, output frame_count,
		input ready);
	modport sink (input valid, input req_type, input codeword, input frame_count,
		output ready);
endinterface

interface lcpg_cut_if;
	logic       valid;
	logic       ready;
	logic       cut_valid;
	logic [7:0] cut_byte;
	logic [9:0] cut_position;
	logic [9:0] rotate_shift;

	modport source (output valid, output cut_valid, output cut_byte, output cut_position,
		output rotate_shift, input ready);
	modport sink (input valid, input cut_valid, input cut_byte, input cut_position,
		input rotate_shift, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/lcpg_seed.sv
// Reseed logic: builds the LFSR load values from codeword and frame count.
`default_nettype none
module lcpg_seed
	import lcpg_pkg::*;
(
	input  logic [CW_W-1:0]   codeword,
	input  logic [CNT_W-1:0]  frame_count,
	input  logic [WORD_W-1:0] word,
	output lcpg_state_t       seeded
);

	logic [2*CNT_W-1:0] pattern;
	logic [4*2*CNT_W-1:0] init_word;
	logic [CW_W-1:0] seed;

	// Count and its inverse, repeated over 64 bits, then mixed with the codeword
	assign pattern   = {~frame_count, frame_count};
	assign init_word = {4{pattern}};
	assign seed      = init_word[CW_W-1:0] ^ codeword;

	assign seeded.a    = seed[A_W-1:0];
	assign seeded.b    = seed[CW_W-1:A_W];
	assign seeded.word = word;

endmodule
`default_nettype wire

FILE: rtl/core/lcpg_advance.sv
// Line step logic: clocks both LFSRs a full line and collects the picked bits.
`default_nettype none
module lcpg_advance
	import lcpg_pkg::*;
(
	input  lcpg_state_t cur,
	output lcpg_state_t nxt
);

	// Every step is a fixed XOR network, so the whole line flattens to shallow logic
	always_comb begin
		logic [A_W-1:0]    a;
		logic [B_W-1:0]    b;
		logic [WORD_W-1:0] w;
		logic [ADDR_W-1:0] rev;
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] idx;
		a = cur.a;
		b = cur.b;
		w = cur.word;
		for (int i = 0; i < SHIFTS_PER_LINE; i++) begin
			a = step_a(a);
			b = step_b(b);
			// low five bits of the reversed b register
			for (int k = 0; k < ADDR_W; k++) begin
				rev[k] = b[B_W-1-k];
			end
			addr = (rev == ADDR_SAT) ? ADDR_TOP : rev;
			// bit addr of reversed a is bit (30 - addr) of a
			idx = ADDR_TOP - addr;
			w = {a[idx], w[WORD_W-1:1]};
		end
		nxt.a    = a;
		nxt.b    = b;
		nxt.word = w;
	end

endmodule
`default_nettype wire

FILE: rtl/core/line_cut_point_generator.sv
// Top level of the line cut point generator.
// Takes one request transaction per clock and returns one cut transaction per request,
// in order. A request is first held in the input register; the reseed load or the
// full 16-shift line advance of both LFSRs is then done combinationally by a
// flattened XOR network, and the cut fields land in the output register. Throughput
// is one transaction per cycle while the sink takes results; the output register
// lets the next request enter while a result waits. Cut byte, cut position and
// rotate shift come from the result word as it stood before the line's shifts;
// reseed acknowledgements carry zero in those fields.
`default_nettype none
`include "line_cut_point_generator_assert.svh"
module line_cut_point_generator
	import lcpg_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	lcpg_req_if.sink     req,
	lcpg_cut_if.source   cut
);

	logic               valid_s1;
	logic               type_s1;
	logic [CW_W-1:0]    cw_s1;
	logic [CNT_W-1:0]   cnt_s1;

	lcpg_state_t        state_q;
	lcpg_state_t        seed_state;
	lcpg_state_t        step_state;

	logic               out_valid_q;
	logic               out_line_q;
	logic [BYTE_W-1:0]  out_byte_q;
	logic [POS_W-1:0]   out_pos_q;
	logic [POS_W-1:0]   out_rot_q;

	logic               adv;
	logic               is_line;
	logic [BYTE_W-1:0]  cb;
	logic [POS_W-1:0]   cut_pos;
	logic [POS_W-1:0]   rot;

	// Stage handshake
	assign adv       = valid_s1 && (!out_valid_q || cut.ready);
	assign req.ready = !valid_s1 || adv;
	assign is_line   = (type_s1 == REQ_LINE);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			type_s1 <= req.req_type;
			cw_s1   <= req.codeword;
			cnt_s1  <= req.frame_count;
		end
	end

	lcpg_seed u_seed (
		.codeword    (cw_s1),
		.frame_count (cnt_s1),
		.word        (state_q.word),
		.seeded      (seed_state)
	);

	lcpg_advance u_advance (
		.cur (state_q),
		.nxt (step_state)
	);

	// Generator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv) begin
			state_q <= is_line ? step_state : seed_state;
		end
	end

	// Cut fields from the result word before this line's shifts
	assign cb      = state_q.word[WORD_W-1:WORD_W-BYTE_W];
	assign cut_pos = CUT_BASE + {{(POS_W-BYTE_W-1){1'b0}}, ~cb, 1'b0};
	assign rot     = LINE_SPAN - cut_pos;

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (cut.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_line_q <= is_line;
			out_byte_q <= is_line ? cb : '0;
			out_pos_q  <= is_line ? cut_pos : '0;
			out_rot_q  <= is_line ? rot : '0;
		end
	end

	assign cut.valid        = out_valid_q;
	assign cut.cut_valid    = out_line_q;
	assign cut.cut_byte     = out_byte_q;
	assign cut.cut_position = out_pos_q;
	assign cut.rotate_shift = out_rot_q;

	// State only moves when a transaction leaves the input register
	`LCPG_ASSERT_NEXT(a_state_hold, clk, arst_n, !adv, $stable(state_q))
	// A loaded LFSR never falls into the all-zero lockup on a line step
	`LCPG_ASSERT_NEXT(a_lfsr_live, clk, arst_n, (state_q.a != '0) && adv && is_line, state_q.a != '0)
	// Line results always span the full line
	`LCPG_ASSERT(a_span, clk, arst_n, !(out_valid_q && out_line_q) || ((out_pos_q + out_rot_q) == LINE_SPAN))
	// Reseed acknowledgements carry zero fields
	`LCPG_ASSERT(a_ack_zero, clk, arst_n, !(out_valid_q && !out_line_q) || ((out_byte_q == '0) && (out_pos_q == '0) && (out_rot_q == '0)))

endmodule
`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the line cut point generator.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	import lcpg_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES   = 10;
	localparam int unsigned RANDOM_ITEMS   = 1450;

	// One expected cut transaction
	typedef struct packed {
		logic       cut_valid;
		logic [7:0] cut_byte;
		logic [9:0] cut_position;
		logic [9:0] rotate_shift;
	} cut_fields_t;

	// Predicts cut transactions from accepted requests and checks what comes out
	class cut_scoreboard;
		localparam logic [30:0] POLY31 = 31'h7BB88888;
		localparam logic [28:0] POLY29 = 29'h17A2C100;

		logic [30:0] lfsr31;
		logic [28:0] lfsr29;
		logic [15:0] pick_word;
		cut_fields_t expected_cuts[$];
		int          failures;

		function new();
			lfsr31 = '0;
			lfsr29 = '0;
			pick_word = '0;
			failures = 0;
		endfunction

		function int pending();
			return expected_cuts.size();
		endfunction

		// One clock of both registers and one picked bit into the word
		function void clock_pair();
			logic [4:0] sel;
			lfsr31 = {1'b0, lfsr31[30:1]} ^ (lfsr31[0] ? POLY31 : 31'd0);
			lfsr29 = {1'b0, lfsr29[28:1]} ^ (lfsr29[0] ? POLY29 : 29'd0);
			for (int k = 0; k < 5; k++)
				sel[k] = lfsr29[28 - k];
			if (sel == 5'd31)
				sel = 5'd30;
			pick_word = {lfsr31[30 - sel], pick_word[15:1]};
		endfunction

		function void take_request(req_kind_t kind, logic [59:0] cw, logic [7:0] cnt);
			cut_fields_t res;
			logic [15:0] pat;
			logic [63:0] init_word;
			logic [59:0] seed;
			int          cut_pos;
			res = '0;
			if (kind == REQ_RESEED) begin
				pat = {~cnt, cnt};
				init_word = {4{pat}};
				seed = init_word[59:0] ^ cw;
				lfsr31 = seed[30:0];
				lfsr29 = seed[59:31];
			end else begin
				res.cut_valid = 1'b1;
				res.cut_byte = pick_word[15:8];
				cut_pos = 105 + 2 * (255 - int'(res.cut_byte));
				res.cut_position = cut_pos[9:0];
				res.rotate_shift = 10'(710 - cut_pos);
				repeat (SHIFTS_PER_LINE) clock_pair();
			end
			expected_cuts.push_back(res);
		endfunction

		function void report_field(string field, logic [9:0] exp_v, logic [9:0] act_v);
			if (act_v !== exp_v) begin
				$display("%0t: %s mismatch, expected %0d actual %0d", $time, field, exp_v, act_v);
				failures++;
			end
		endfunction

		function void check_cut(cut_fields_t act);
			cut_fields_t exp_cut;
			if (expected_cuts.size() == 0) begin
				$display("%0t: unexpected cut transaction, expected none actual %h", $time, act);
				failures++;
				return;
			end
			exp_cut = expected_cuts.pop_front();
			report_field("cut_valid", 10'(exp_cut.cut_valid), 10'(act.cut_valid));
			report_field("cut_byte", 10'(exp_cut.cut_byte), 10'(act.cut_byte));
			report_field("cut_position", exp_cut.cut_position, act.cut_position);
			report_field("rotate_shift", exp_cut.rotate_shift, act.rotate_shift);
		endfunction
	endclass

	logic clk;
	logic arst_n;

	lcpg_req_if req_ch();
	lcpg_cut_if cut_ch();

	line_cut_point_generator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.cut    (cut_ch)
	);

	cut_scoreboard sb = new();
	bit src_burst;
	bit snk_burst;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int draw_wait(bit burst);
		return burst ? 0 : int'($urandom_range(0, 16));
	endfunction

	// Sends one request transaction; starts and ends on a falling edge
	task automatic send_req(req_kind_t kind, logic [59:0] cw, logic [7:0] cnt);
		int gap;
		gap = draw_wait(src_burst);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.codeword <= cw;
		req_ch.frame_count <= cnt;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		sb.take_request(kind, cw, cnt);
		if ($urandom_range(0, 39) == 0)
			src_burst = !src_burst;
		@(negedge clk);
	endtask

	function automatic logic [59:0] rand_cw();
		return 60'({$urandom(), $urandom()});
	endfunction

	// Result side: random stalls, check each accepted transaction
	initial begin
		int stall;
		cut_ch.ready = 1'b0;
		snk_burst = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = draw_wait(snk_burst);
			if (stall > 0) begin
				cut_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			cut_ch.ready <= 1'b1;
			do @(posedge clk); while (cut_ch.valid !== 1'b1);
			sb.check_cut({cut_ch.cut_valid, cut_ch.cut_byte, cut_ch.cut_position,
				cut_ch.rotate_shift});
			if ($urandom_range(0, 39) == 0)
				snk_burst = !snk_burst;
			@(negedge clk);
		end
	end

	// Watchdog: cycles with no transaction on either side
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (cut_ch.valid && cut_ch.ready) || !arst_n)
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: failure");
		$finish;
	end

	// Stimulus and end of run
	initial begin
		int sent;
		int lines;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_RESEED;
		req_ch.codeword = '0;
		req_ch.frame_count = '0;
		src_burst = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Zero registers after reset; codeword and count ignored on lines
		send_req(REQ_LINE, '1, 8'hFF);
		send_req(REQ_LINE, 60'h5A5_A5A5_A5A5_A5A5, 8'h3C);
		// Seed extremes
		send_req(REQ_RESEED, '0, 8'h00);
		repeat (3) send_req(REQ_LINE, '0, 8'h00);
		send_req(REQ_RESEED, '1, 8'hFF);
		repeat (3) send_req(REQ_LINE, '0, 8'h00);
		send_req(REQ_RESEED, '0, 8'hFF);
		repeat (2) send_req(REQ_LINE, '1, 8'h00);
		send_req(REQ_RESEED, '1, 8'h00);
		repeat (2) send_req(REQ_LINE, '0, 8'hFF);
		send_req(REQ_RESEED, 60'hA5A_5A5A_5A5A_5A5A, 8'h5A);
		send_req(REQ_RESEED, 60'h0F0_F0F0_F0F0_F0F0, 8'hA5);
		repeat (3) send_req(REQ_LINE, '1, 8'hFF);

		// Mostly frames: a reseed and a run of lines; some stray transactions
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 7) == 0) begin
				send_req($urandom_range(0, 1) ? REQ_LINE : REQ_RESEED, rand_cw(),
					8'($urandom()));
				sent++;
			end else begin
				send_req(REQ_RESEED, rand_cw(), 8'($urandom()));
				lines = $urandom_range(1, 40);
				repeat (lines) send_req(REQ_LINE, rand_cw(), 8'($urandom()));
				sent += lines + 1;
			end
		end
		req_ch.valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire
